// ===== rtl/core/jft_pkg.sv =====
// Shared types, constants and register indexes for the joint friction torque pipeline.
// No dependencies. Used by every module under rtl/core except jft_checker.
package jft_pkg;

  localparam int XQ_W  = 19;   // |v|*inv_stribeck >> 16 while below 8.0
  localparam int TV_W  = 24;   // viscous term magnitude
  localparam int B_W   = 31;   // Q1.30 base / exp value, at most 1.0
  localparam int REM_W = 32;   // divider remainder, below the divisor
  localparam int DEN_W = 32;   // divisor 1.0 + e, at most 2.0 in Q.30
  localparam int QUO_W = 31;   // tanh quotient, at most 1.0 in Q.30
  localparam int SQ_STEPS  = 16;
  localparam int DIV_STEPS = 31;

  localparam logic [B_W-1:0] ONE_Q30 = 31'h4000_0000;

  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_STRIBECK_GAIN = 3'd0;
  localparam logic [IDX_W-1:0] REG_COULOMB_TORQUE = 3'd1;
  localparam logic [IDX_W-1:0] REG_INV_STRIBECK_VEL = 3'd2;
  localparam logic [IDX_W-1:0] REG_INV_COULOMB_VEL = 3'd3;
  localparam logic [IDX_W-1:0] REG_VISCOUS_COEFF = 3'd4;

  localparam logic [31:0] RST_STRIBECK_GAIN = 32'd125979;
  localparam logic [31:0] RST_COULOMB_TORQUE = 32'd131072;
  localparam logic [23:0] RST_INV_STRIBECK_VEL = 24'd36204;
  localparam logic [23:0] RST_INV_COULOMB_VEL = 24'd512000;
  localparam logic [23:0] RST_VISCOUS_COEFF = 24'd16777;

  // Per-sample data that rides alongside the exp and divide chains.
  typedef struct packed {
    logic              neg;
    logic signed [31:0] cmd;
    logic [TV_W-1:0]   term_v;
    logic              s_zero;
    logic              c_sat;
    logic [XQ_W-1:0]   xq;
  } side_t;

  typedef struct packed {
    side_t          side;
    logic [B_W-1:0] b_s;
    logic [B_W-1:0] b_c;
  } sq_t;

  typedef struct packed {
    side_t            side;
    logic [B_W-1:0]   e_s;
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic             nbit;
    logic [QUO_W-1:0] quo;
  } dv_t;

endpackage

// ===== rtl/core/jft_sq_cell.sv =====
// One squaring cell of the exp(-y) chain: both lanes square their Q1.30 base once.
// Depends on jft_pkg.
module jft_sq_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  jft_pkg::sq_t  in_data,
  output logic          out_vld,
  output jft_pkg::sq_t  out_data
);

  logic [61:0] prod_s;
  logic [61:0] prod_c;

  // round half up, drop 30 fraction bits
  assign prod_s = 62'(in_data.b_s) * 62'(in_data.b_s) + 62'(64'h2000_0000);
  assign prod_c = 62'(in_data.b_c) * 62'(in_data.b_c) + 62'(64'h2000_0000);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.side <= in_data.side;
      out_data.b_s  <= prod_s[60:30];
      out_data.b_c  <= prod_c[60:30];
    end
  end

endmodule

// ===== rtl/core/jft_div_cell.sv =====
// One restoring-division cell: retires one quotient bit of the tanh ratio.
// Depends on jft_pkg.
module jft_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  jft_pkg::dv_t  in_data,
  output logic          out_vld,
  output jft_pkg::dv_t  out_data
);

  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  assign shifted = {in_data.rem, in_data.nbit};
  assign diff    = shifted - {1'b0, in_data.den};
  assign ge      = shifted >= {1'b0, in_data.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.side <= in_data.side;
      out_data.e_s  <= in_data.e_s;
      out_data.den  <= in_data.den;
      out_data.nbit <= 1'b0;  // lower dividend bits are zero
      out_data.rem  <= ge ? diff[31:0] : shifted[31:0];
      out_data.quo  <= {in_data.quo[jft_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/joint_friction_torque_top.sv =====
// Top level of the joint friction torque evaluator.
// Depends on jft_pkg, jft_sq_cell and jft_div_cell.
//
// Takes one joint sample (velocity Q8.24, command torque Q16.16) per cycle and returns
// friction = G*x*exp(-x^2) + C*tanh(z) + c*|v|, signed like v, and command minus friction,
// both saturated to 32 bits. From input transaction to result a sample passes through
// 2 front stages (abs value and products, then square of x), 16 squaring cells that
// form exp(-y) for both the Stribeck and Coulomb lanes, 31 divider cells that
// produce the tanh quotient one bit each, and 4 back stages (Stribeck product,
// gain products, sum and sign, net torque into the output register). The whole chain
// advances together whenever the output register is empty or being taken, so a new
// transaction is accepted every cycle unless the result side stalls. Configuration
// writes are always accepted; write them only while no sample is in flight.

module joint_friction_torque_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  joint_velocity,
  input  logic signed [31:0]  command_torque,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  friction_out,
  output logic signed [31:0]  net_torque,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [jft_pkg::IDX_W-1:0] cfg_index,
  input  logic [31:0]         cfg_data
);

  // ---------------- configuration registers ----------------
  logic [31:0] stribeck_gain;
  logic [31:0] coulomb_torque;
  logic [23:0] inv_stribeck_velocity;
  logic [23:0] inv_coulomb_velocity;
  logic [23:0] viscous_coeff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stribeck_gain         <= jft_pkg::RST_STRIBECK_GAIN;
      coulomb_torque        <= jft_pkg::RST_COULOMB_TORQUE;
      inv_stribeck_velocity <= jft_pkg::RST_INV_STRIBECK_VEL;
      inv_coulomb_velocity  <= jft_pkg::RST_INV_COULOMB_VEL;
      viscous_coeff         <= jft_pkg::RST_VISCOUS_COEFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jft_pkg::REG_STRIBECK_GAIN:    stribeck_gain         <= cfg_data;
        jft_pkg::REG_COULOMB_TORQUE:   coulomb_torque        <= cfg_data;
        jft_pkg::REG_INV_STRIBECK_VEL: inv_stribeck_velocity <= cfg_data[23:0];
        jft_pkg::REG_INV_COULOMB_VEL:  inv_coulomb_velocity  <= cfg_data[23:0];
        jft_pkg::REG_VISCOUS_COEFF:    viscous_coeff         <= cfg_data[23:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------- flow control ----------------
  // Advance the whole chain when the output register is free or being drained.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: magnitude and the three velocity products ----------------
  logic [31:0] mag;
  assign mag = joint_velocity[31] ? 32'(-joint_velocity) : 32'(joint_velocity);

  logic               v1;
  logic               neg1;
  logic signed [31:0] cmd1;
  logic [55:0]        x1;
  logic [55:0]        z1;
  logic [55:0]        vis1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg1 <= joint_velocity[31];
      cmd1 <= command_torque;
      x1   <= 56'(mag) * 56'(inv_stribeck_velocity);
      z1   <= 56'(mag) * 56'(inv_coulomb_velocity);
      vis1 <= 56'(mag) * 56'(viscous_coeff);
    end
  end

  // ---------------- stage 2: x squared, range flags, viscous rounding ----------------
  logic [56:0] vis_rnd;
  logic [37:0] xsq;
  assign vis_rnd = {1'b0, vis1} + 57'h0_8000_0000;
  assign xsq     = 38'(x1[34:16]) * 38'(x1[34:16]);

  logic                v2;
  jft_pkg::side_t      side2;
  logic [21:0]         y2;
  logic [18:0]         zh2;   // (2*zq) >> 2

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side2.neg    <= neg1;
      side2.cmd    <= cmd1;
      side2.term_v <= vis_rnd[55:32];
      side2.s_zero <= |x1[55:35];   // x >= 8.0: Stribeck term vanishes
      side2.c_sat  <= |z1[55:36];   // z >= 16.0: tanh is exactly 1
      side2.xq     <= x1[34:16];
      y2           <= xsq[37:16];
      zh2          <= z1[35:17];
    end
  end

  // ---------------- squaring chain: exp(-y) as (1 - y/2^16)^(2^16) ----------------
  jft_pkg::sq_t sq_data [0:jft_pkg::SQ_STEPS];
  logic         sq_vld  [0:jft_pkg::SQ_STEPS];

  assign sq_vld[0]       = v2;
  assign sq_data[0].side = side2;
  assign sq_data[0].b_s  = jft_pkg::ONE_Q30 - 31'(y2[21:2]);
  assign sq_data[0].b_c  = jft_pkg::ONE_Q30 - 31'(zh2);

  for (genvar i = 0; i < jft_pkg::SQ_STEPS; i++) begin : g_sq
    jft_sq_cell u_sq (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_vld   (sq_vld[i]),
      .in_data  (sq_data[i]),
      .out_vld  (sq_vld[i+1]),
      .out_data (sq_data[i+1])
    );
  end

  // ---------------- divider chain: tanh = (1 - e) / (1 + e) ----------------
  jft_pkg::dv_t dv_data [0:jft_pkg::DIV_STEPS];
  logic         dv_vld  [0:jft_pkg::DIV_STEPS];
  logic [30:0]  tanh_num;

  assign tanh_num = jft_pkg::ONE_Q30 - sq_data[jft_pkg::SQ_STEPS].b_c;

  assign dv_vld[0]       = sq_vld[jft_pkg::SQ_STEPS];
  assign dv_data[0].side = sq_data[jft_pkg::SQ_STEPS].side;
  assign dv_data[0].e_s  = sq_data[jft_pkg::SQ_STEPS].b_s;
  // leading dividend bits are already folded in: start from numerator >> 1
  assign dv_data[0].rem  = 32'(tanh_num[30:1]);
  assign dv_data[0].nbit = tanh_num[0];
  assign dv_data[0].den  = 32'(jft_pkg::ONE_Q30) + 32'(sq_data[jft_pkg::SQ_STEPS].b_c);
  assign dv_data[0].quo  = '0;

  for (genvar j = 0; j < jft_pkg::DIV_STEPS; j++) begin : g_div
    jft_div_cell u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_vld   (dv_vld[j]),
      .in_data  (dv_data[j]),
      .out_vld  (dv_vld[j+1]),
      .out_data (dv_data[j+1])
    );
  end

  // ---------------- stage P: Stribeck product x*exp(-x^2), tanh select ----------------
  // x*exp(-x^2) peaks near 0.43, so p stays well inside 32 bits of Q.30.
  jft_pkg::dv_t dv_end;
  logic [49:0]  xe;
  assign dv_end = dv_data[jft_pkg::DIV_STEPS];
  assign xe     = 50'(dv_end.side.xq) * 50'(dv_end.e_s);

  logic               vp;
  logic               negp;
  logic signed [31:0] cmdp;
  logic [23:0]        tvp;
  logic               szp;
  logic [31:0]        pp;
  logic [30:0]        tqp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (adv) begin
      vp <= dv_vld[jft_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      negp <= dv_end.side.neg;
      cmdp <= dv_end.side.cmd;
      tvp  <= dv_end.side.term_v;
      szp  <= dv_end.side.s_zero;
      pp   <= xe[47:16];
      tqp  <= dv_end.side.c_sat ? jft_pkg::ONE_Q30 : dv_end.quo;
    end
  end

  // ---------------- stage T: gain products ----------------
  logic [63:0] gs;
  logic [62:0] gc;
  assign gs = 64'(stribeck_gain) * 64'(pp) + 64'h2000_0000;
  assign gc = 63'(coulomb_torque) * 63'(tqp) + 63'(64'h2000_0000);

  logic               vt;
  logic               negt;
  logic signed [31:0] cmdt;
  logic [23:0]        tvt;
  logic [33:0]        tst;
  logic [32:0]        tct;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else if (adv) begin
      vt <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      negt <= negp;
      cmdt <= cmdp;
      tvt  <= tvp;
      tst  <= szp ? '0 : gs[63:30];
      tct  <= gc[62:30];
    end
  end

  // ---------------- stage F: sum, sign, saturate ----------------
  logic [37:0]        total;
  logic               big;
  logic signed [31:0] fr;
  assign total = 38'(tst) + 38'(tct) + 38'(tvt);
  assign big   = |total[37:31];

  always_comb begin
    if (big) begin
      fr = negt ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      fr = negt ? -$signed({1'b0, total[30:0]}) : $signed({1'b0, total[30:0]});
    end
  end

  logic               vf;
  logic signed [31:0] frf;
  logic signed [31:0] cmdf;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (adv) begin
      vf <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frf  <= fr;
      cmdf <= cmdt;
    end
  end

  // ---------------- stage O: net torque into the output register ----------------
  logic signed [32:0] diff;
  logic signed [31:0] net;
  assign diff = 33'(cmdf) - 33'(frf);

  always_comb begin
    if (diff[32] != diff[31]) begin
      net = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      net = diff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      friction_out <= frf;
      net_torque   <= net;
    end
  end

endmodule

// ===== rtl/core/jft_checker.sv =====
// Port-level checker for joint_friction_torque_top, attached by bind.
// No package dependencies; watches only the handshake and result ports.
module jft_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [31:0]  friction_out,
  input logic signed [31:0]  net_torque,
  input logic                cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(friction_out) && $stable(net_torque))
    else $error("result changed while stalled");

  a_ready_tracks_output: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("register write channel not ready");

endmodule

bind joint_friction_torque_top jft_checker u_jft_checker (.*);
